// ===== rtl/b2rcs_pkg.sv =====
package b2rcs_pkg;

	localparam int SLOT_W        = 8;
	localparam int LANE_W        = 4;
	localparam int BIN_W         = 12;
	localparam int RES_W         = 11;
	localparam int SAMPLE_W      = 16;
	localparam int IQ_W          = 2 * SAMPLE_W;
	localparam int BINS_PER_SLOT = 16;
	localparam int RES_PER_SLOT  = 8;
	localparam int RUN_W         = 3;
	localparam int SLOTS         = 256;
	localparam int RESONATORS    = 2048;
	localparam int STORE_DEPTH   = SLOTS * BINS_PER_SLOT;
	localparam int STORE_AW      = 12;
	localparam int MAP_AW        = 11;

	// Run start at or above this value returns to zero.
	localparam logic [RES_W-1:0] RES_WRAP = RES_W'(RESONATORS - RES_PER_SLOT);
	localparam logic [RES_W-1:0] RES_STEP = RES_W'(RES_PER_SLOT);
	localparam logic [RUN_W-1:0] RUN_LAST = RUN_W'(RES_PER_SLOT - 1);

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_MAP_WR = 1'b1;

	typedef struct packed {
		logic                       op;
		logic [SLOT_W-1:0]          slot;
		logic [LANE_W-1:0]          lane;
		logic [BIN_W-1:0]           bin_index;
		logic signed [SAMPLE_W-1:0] i_sample;
		logic signed [SAMPLE_W-1:0] q_sample;
	} in_item_t;

	typedef struct packed {
		logic [RES_W-1:0]           resonator_id;
		logic signed [SAMPLE_W-1:0] i_value;
		logic signed [SAMPLE_W-1:0] q_value;
		logic                       last_of_run;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_MAP_RD = 5'b00100,
		ST_IQ_RD  = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

endpackage

// ===== rtl/b2rcs_ram.sv =====
module b2rcs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/bin_to_resonator_channel_select.sv =====
// Run: a lane-0 sample starts a run of eight results, each made by a map read, a store read
// and an emit; the emit waits while the result output is stalled.
// Input: other samples and map writes are taken in idle; no input is taken until a run ends.
// Reset: arst_n clears control state, then a clearing pass over all 4096 store addresses zeroes
// the I/Q store and the bin map, during which no transaction is accepted.
module bin_to_resonator_channel_select
	import b2rcs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      sample_valid,
	output logic      sample_ready,
	input  in_item_t  sample_item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result_item
);

	state_t                     state_q;
	logic [STORE_AW-1:0]        clr_cnt_q;
	logic [SLOT_W-1:0]          slot_q;
	logic [RUN_W-1:0]           k_q;
	logic [RES_W-1:0]           res_base_q;
	logic [IQ_W-1:0]            sample_q;
	logic                       out_valid_q;
	out_item_t                  out_q;

	logic                       accept;
	logic                       emit_load;
	logic                       map_wr_en;
	logic [MAP_AW-1:0]          map_wr_addr;
	logic [BIN_W-1:0]           map_wr_data;
	logic [BIN_W-1:0]           map_rd_data;
	logic                       iq_wr_en;
	logic [STORE_AW-1:0]        iq_wr_addr;
	logic [IQ_W-1:0]            iq_wr_data;
	logic [IQ_W-1:0]            iq_rd_data;

	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid && sample_ready;
	assign emit_load    = (state_q == ST_EMIT) && (!out_valid_q || result_ready);
	assign result_valid = out_valid_q;
	assign result_item  = out_q;

	always_comb begin
		map_wr_en   = 1'b0;
		map_wr_addr = {sample_item.slot, sample_item.lane[RUN_W-1:0]};
		map_wr_data = sample_item.bin_index;
		iq_wr_en    = 1'b0;
		iq_wr_addr  = {sample_item.slot, sample_item.lane};
		iq_wr_data  = {sample_item.i_sample, sample_item.q_sample};
		if (state_q == ST_CLEAR) begin
			map_wr_en   = 1'b1;
			map_wr_addr = clr_cnt_q[MAP_AW-1:0];
			map_wr_data = '0;
			iq_wr_en    = 1'b1;
			iq_wr_addr  = clr_cnt_q;
			iq_wr_data  = '0;
		end else if (accept) begin
			if (sample_item.op == OP_MAP_WR) begin
				map_wr_en = (sample_item.lane < LANE_W'(RES_PER_SLOT));
			end else begin
				// A lane-0 sample is stored only after its run has read the store.
				iq_wr_en = (sample_item.lane != '0);
			end
		end else if (emit_load && k_q == RUN_LAST) begin
			iq_wr_en   = 1'b1;
			iq_wr_addr = {slot_q, {LANE_W{1'b0}}};
			iq_wr_data = sample_q;
		end
	end

	b2rcs_ram #(
		.WIDTH(BIN_W),
		.DEPTH(RESONATORS)
	) u_map_ram (
		.clk    (clk),
		.wr_en  (map_wr_en),
		.wr_addr(map_wr_addr),
		.wr_data(map_wr_data),
		.rd_en  (state_q == ST_MAP_RD),
		.rd_addr({slot_q, k_q}),
		.rd_data(map_rd_data)
	);

	b2rcs_ram #(
		.WIDTH(IQ_W),
		.DEPTH(STORE_DEPTH)
	) u_iq_ram (
		.clk    (clk),
		.wr_en  (iq_wr_en),
		.wr_addr(iq_wr_addr),
		.wr_data(iq_wr_data),
		.rd_en  (state_q == ST_IQ_RD),
		.rd_addr(map_rd_data),
		.rd_data(iq_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			k_q         <= '0;
			res_base_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (result_valid && result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && sample_item.op == OP_SAMPLE && sample_item.lane == '0) begin
						k_q     <= '0;
						state_q <= ST_MAP_RD;
					end
				end
				ST_MAP_RD: begin
					state_q <= ST_IQ_RD;
				end
				ST_IQ_RD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_load) begin
						k_q <= k_q + 1'b1;
						if (k_q == RUN_LAST) begin
							res_base_q <= (res_base_q >= RES_WRAP) ? '0 : res_base_q + RES_STEP;
							state_q    <= ST_IDLE;
						end else begin
							state_q <= ST_MAP_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q   <= sample_item.slot;
			sample_q <= {sample_item.i_sample, sample_item.q_sample};
		end
		if (emit_load) begin
			out_q.resonator_id <= res_base_q + RES_W'(k_q);
			out_q.i_value      <= iq_rd_data[IQ_W-1:SAMPLE_W];
			out_q.q_value      <= iq_rd_data[SAMPLE_W-1:0];
			out_q.last_of_run  <= (k_q == RUN_LAST);
		end
	end

endmodule

// ===== rtl/b2rcs_checker.sv =====
module b2rcs_checker
	import b2rcs_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      sample_valid,
	input logic      sample_ready,
	input in_item_t  sample_item,
	input logic      result_valid,
	input logic      result_ready,
	input out_item_t result_item
);

	logic [RES_W-1:0] exp_id_q;

	// Resonator ids run consecutively across runs, wrapping at the resonator count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_id_q <= '0;
		end else if (result_valid && result_ready) begin
			exp_id_q <= result_item.resonator_id + 1'b1;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_item))
		else $error("result changed while stalled");

	a_id_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_item.resonator_id == exp_id_q)
		else $error("resonator id out of sequence");

	a_busy_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !result_item.last_of_run |-> !sample_ready)
		else $error("input taken in the middle of a run");

	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready && sample_item.op == OP_SAMPLE && sample_item.lane == '0
		|=> !sample_ready)
		else $error("lane-0 sample did not start a run");

endmodule

bind bin_to_resonator_channel_select b2rcs_checker u_b2rcs_checker (.*);
